// ----- rtl/key_pointer_accelerator_assert.svh -----
// Assertion macros shared by the key pointer accelerator RTL.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef KEY_POINTER_ACCELERATOR_ASSERT_SVH
`define KEY_POINTER_ACCELERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KPA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KPA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kpa_pkg.sv -----
// Package for the key pointer accelerator: field widths, register indexes,
// direction and exit codes, and the acceleration step table. No dependencies.
package kpa_pkg;

  localparam int unsigned DIR_W    = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned POS_W    = 15;
  localparam int unsigned NEWPOS_W = 16;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned NUM_DIRS = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Highest repeat count that still advances; above it the step is capped.
  localparam logic [CNT_W-1:0] REPEAT_CAP = 5'd20;

  typedef logic [DIR_W-1:0]    dir_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_WINDOW = 2'd0,
    REG_SINGLE_STEP   = 2'd1,
    REG_MAX_STEP      = 2'd2
  } cfg_reg_t;

  localparam dir_t DIR_LEFT       = 3'd0;
  localparam dir_t DIR_RIGHT      = 3'd1;
  localparam dir_t DIR_UP         = 3'd2;
  localparam dir_t DIR_DOWN       = 3'd3;
  localparam dir_t DIR_LEFT_UP    = 3'd4;
  localparam dir_t DIR_LEFT_DOWN  = 3'd5;
  localparam dir_t DIR_RIGHT_UP   = 3'd6;
  localparam dir_t DIR_RIGHT_DOWN = 3'd7;

  localparam code_t EXIT_INSIDE = 3'd0;
  localparam code_t EXIT_LEFT   = 3'd1;
  localparam code_t EXIT_RIGHT  = 3'd2;
  localparam code_t EXIT_BELOW  = 3'd3;
  localparam code_t EXIT_ABOVE  = 3'd4;

  localparam logic [WIN_W-1:0]  RESET_REPEAT_WINDOW = 16'd40;
  localparam logic [STEP_W-1:0] RESET_SINGLE_STEP   = 8'd8;
  localparam logic [STEP_W-1:0] RESET_MAX_STEP      = 8'd64;

  // floor(5 * 1.3^n), saturated at 255.
  function automatic step_t step_table(input cnt_t n);
    step_t s;
    case (n)
      5'd0:  s = 8'd5;
      5'd1:  s = 8'd6;
      5'd2:  s = 8'd8;
      5'd3:  s = 8'd10;
      5'd4:  s = 8'd14;
      5'd5:  s = 8'd18;
      5'd6:  s = 8'd24;
      5'd7:  s = 8'd31;
      5'd8:  s = 8'd40;
      5'd9:  s = 8'd53;
      5'd10: s = 8'd68;
      5'd11: s = 8'd89;
      5'd12: s = 8'd116;
      5'd13: s = 8'd151;
      5'd14: s = 8'd196;
      default: s = 8'd255;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/key_pointer_accelerator.sv -----
// An accepted input transaction's result is loaded into the output register in the next cycle.
// Throughput: one press per cycle; the only hold-up is a full output register that is stalled.
// Reset (rst_n, synchronous, active low) clears the repeat count, all eight last-press times,
// the output valid flag and sets the registers to window 40, single step 8, maximum step 64.
// Top level of the key pointer accelerator; uses kpa_pkg and the assertion macro header.
module key_pointer_accelerator (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input channel: one cursor-key press per transaction.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kpa_pkg::DIR_W-1:0]           in_direction,
  input  logic [kpa_pkg::TIME_W-1:0]          in_press_time,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_pointer_x,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_pointer_y,
  input  logic                                in_box_valid,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_box_left,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_box_bottom,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_box_right,
  input  logic signed [kpa_pkg::POS_W-1:0]    in_box_top,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [kpa_pkg::NEWPOS_W-1:0] out_new_x,
  output logic signed [kpa_pkg::NEWPOS_W-1:0] out_new_y,
  output logic                                out_move_pointer,
  output logic [kpa_pkg::CODE_W-1:0]          out_exit_code
);
  import kpa_pkg::*;
  `include "key_pointer_accelerator_assert.svh"

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is accepted and ignored.
  logic [WIN_W-1:0] repeat_window_r;
  step_t            single_step_r;
  step_t            max_step_r;

  // Press history: one shared repeat count and one timestamp per direction.
  cnt_t              repeat_count_r, repeat_count_nxt;
  logic [TIME_W-1:0] last_press_r [NUM_DIRS];

  // Output register.
  logic                       out_valid_r;
  logic signed [NEWPOS_W-1:0] new_x_r, new_x_nxt;
  logic signed [NEWPOS_W-1:0] new_y_r, new_y_nxt;
  logic                       move_r, move_nxt;
  code_t                      code_r, code_nxt;

  logic              in_accept;
  logic [TIME_W-1:0] time_diff;
  logic              is_repeat;
  step_t             step;
  step_t             table_step;
  cnt_t              count_inc;
  logic signed [NEWPOS_W-1:0] dx, dy;
  logic signed [NEWPOS_W-1:0] step_s;

  assign cfg_ready = 1'b1;

  // The output register can take a new result when it is empty or is being
  // drained in this very cycle, so the input only waits on a stalled result.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Signed 32-bit time difference with wraparound. A negative difference
  // always counts as a repeat; otherwise the upper half must be zero and the
  // lower half no larger than the window.
  assign time_diff = in_press_time - last_press_r[in_direction];
  assign is_repeat = time_diff[TIME_W-1] |
                     ((time_diff[TIME_W-2:WIN_W] == '0) &&
                      (time_diff[WIN_W-1:0] <= repeat_window_r));

  assign count_inc  = repeat_count_r + cnt_t'(1);
  assign table_step = step_table(count_inc);

  always_comb begin
    repeat_count_nxt = repeat_count_r;
    step             = single_step_r;
    if (is_repeat) begin
      if (repeat_count_r > REPEAT_CAP) begin
        step = max_step_r;
      end else begin
        repeat_count_nxt = count_inc;
        step = (table_step > max_step_r) ? max_step_r : table_step;
      end
    end else begin
      repeat_count_nxt = '0;
    end
  end

  // Diagonals move by the same amount on both axes; up is positive y.
  assign step_s = $signed({{(NEWPOS_W-STEP_W){1'b0}}, step});

  always_comb begin
    dx = '0;
    dy = '0;
    case (in_direction)
      DIR_LEFT:       dx = -step_s;
      DIR_RIGHT:      dx = step_s;
      DIR_UP:         dy = step_s;
      DIR_DOWN:       dy = -step_s;
      DIR_LEFT_UP:    begin dx = -step_s; dy = step_s;  end
      DIR_LEFT_DOWN:  begin dx = -step_s; dy = -step_s; end
      DIR_RIGHT_UP:   begin dx = step_s;  dy = step_s;  end
      default:        begin dx = step_s;  dy = -step_s; end
    endcase
  end

  // New position and box check. The checks run in edge order so that the
  // last failing edge sets the exit code. A zero step never moves.
  always_comb begin
    new_x_nxt = NEWPOS_W'(in_pointer_x) + dx;
    new_y_nxt = NEWPOS_W'(in_pointer_y) + dy;
    code_nxt  = EXIT_INSIDE;
    move_nxt  = 1'b0;
    if (step != '0) begin
      if (in_box_valid) begin
        if (new_x_nxt < NEWPOS_W'(in_box_left))   code_nxt = EXIT_LEFT;
        if (new_x_nxt > NEWPOS_W'(in_box_right))  code_nxt = EXIT_RIGHT;
        if (new_y_nxt < NEWPOS_W'(in_box_bottom)) code_nxt = EXIT_BELOW;
        if (new_y_nxt > NEWPOS_W'(in_box_top))    code_nxt = EXIT_ABOVE;
      end
      move_nxt = (code_nxt == EXIT_INSIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_window_r <= RESET_REPEAT_WINDOW;
      single_step_r   <= RESET_SINGLE_STEP;
      max_step_r      <= RESET_MAX_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_REPEAT_WINDOW: repeat_window_r <= cfg_data[WIN_W-1:0];
        REG_SINGLE_STEP:   single_step_r   <= cfg_data[STEP_W-1:0];
        REG_MAX_STEP:      max_step_r      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_count_r <= '0;
      for (int i = 0; i < NUM_DIRS; i++) begin
        last_press_r[i] <= '0;
      end
    end else if (in_accept) begin
      repeat_count_r             <= repeat_count_nxt;
      last_press_r[in_direction] <= in_press_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload carries no reset; it is loaded with every accepted press.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_x_r <= new_x_nxt;
      new_y_r <= new_y_nxt;
      move_r  <= move_nxt;
      code_r  <= code_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_x        = new_x_r;
  assign out_new_y        = new_y_r;
  assign out_move_pointer = move_r;
  assign out_exit_code    = code_r;

  // The count saturates one above the cap and never runs past it.
  `KPA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, repeat_count_r <= REPEAT_CAP + cnt_t'(1), "repeat count beyond cap")
  // A press that is not a repeat leaves the count cleared.
  `KPA_ASSERT_NEXT(a_count_clear, clk, rst_n, in_accept && !is_repeat, repeat_count_r == '0, "repeat count not cleared")
  // Every accepted press leaves a result in the output register.
  `KPA_ASSERT_NEXT(a_result_loaded, clk, rst_n, in_accept, out_valid_r, "accepted press produced no result")
  // A pointer move is only ever reported together with an inside code.
  `KPA_ASSERT_NOW(a_move_inside, clk, rst_n, out_valid_r && move_r, code_r == EXIT_INSIDE, "move with exit code")
  // For an accepted left press, the stored left timestamp is the press time.
  `KPA_ASSERT_NEXT(a_time_stored, clk, rst_n, in_accept && in_direction == DIR_LEFT, last_press_r[0] == $past(in_press_time), "last press time not stored")

endmodule
